@@ design/tce_pkg.sv @@
package tce_pkg;

  // screen geometry
  localparam int unsigned COLUMNS    = 80;
  localparam int unsigned ROWS       = 25;
  localparam int unsigned CELL_COUNT = ROWS * COLUMNS;

  // field widths
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned ATTR_W   = 8;
  localparam int unsigned POS_W    = 11;
  localparam int unsigned CELL_W   = CHAR_W + ATTR_W;
  localparam int unsigned ADDR_W   = $clog2(CELL_COUNT);

  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUT       = 3'd0,
    ACT_NEWLINE   = 3'd1,
    ACT_BACKSPACE = 3'd2,
    ACT_CLEAR     = 3'd3,
    ACT_SET       = 3'd4,
    ACT_READ      = 3'd5,
    ACT_HEX       = 3'd6
  } tce_action_e;

  function automatic logic [CHAR_W-1:0] hex_digit(input logic [3:0] nib);
    logic [CHAR_W-1:0] ch;
    if (nib < 4'd10) begin
      ch = 8'h30 + {4'd0, nib};
    end else begin
      ch = 8'h37 + {4'd0, nib};
    end
    return ch;
  endfunction

endpackage

@@ design/tce_in_if.sv @@
interface tce_in_if;
  logic                           valid;
  logic                           ready;
  logic [tce_pkg::ACTION_W-1:0]   action;
  logic [tce_pkg::CHAR_W-1:0]     char_code;
  logic [tce_pkg::POS_W-1:0]      position;

  modport source (output valid, output action, output char_code, output position,
                  input ready);
  modport sink (input valid, input action, input char_code, input position,
                output ready);
endinterface

@@ design/tce_out_if.sv @@
interface tce_out_if;
  logic                        valid;
  logic                        ready;
  logic [tce_pkg::POS_W-1:0]   cursor_cell;
  logic [tce_pkg::CHAR_W-1:0]  cell_char;
  logic [tce_pkg::ATTR_W-1:0]  cell_attr;

  modport source (output valid, output cursor_cell, output cell_char, output cell_attr,
                  input ready);
  modport sink (input valid, input cursor_cell, input cell_char, input cell_attr,
                output ready);
endinterface

@@ design/tce_cfg_if.sv @@
interface tce_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [tce_pkg::ATTR_W-1:0]  text_attribute;

  modport source (output valid, output text_attribute, input ready);
  modport sink (input valid, input text_attribute, output ready);
endinterface

@@ design/tce_ram.sv @@
module tce_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ design/text_console_engine_top.sv @@
// Text console engine: a ROWS x COLUMNS screen of {char, attribute} cells held in one
// single-port-write, single-port-read RAM, plus a cursor. One action per input transaction,
// one result transaction per action. After reset the block sweeps the RAM to blanks with
// attribute 0x0F, one cell a cycle, and takes no action until that is done; attribute writes
// are taken at any time. Set cursor finds the row base by repeated add of COLUMNS. A put
// char with the cursor past the end, and a newline off the last row, first scroll the screen:
// the RAM is streamed one cell a cycle through its read and write ports, then the last row
// is blanked.
module text_console_engine_top (
  input  logic   clk_i,
  input  logic   rst_ni,
  tce_cfg_if.sink  cfg_chan,
  tce_in_if.sink   in_chan,
  tce_out_if.source out_chan
);

  typedef enum logic [8:0] {
    ST_INIT   = 9'b000000001,
    ST_IDLE   = 9'b000000010,
    ST_PUT    = 9'b000000100,
    ST_COPY   = 9'b000001000,
    ST_BLANK  = 9'b000010000,
    ST_CLEAR  = 9'b000100000,
    ST_SETROW = 9'b001000000,
    ST_RDWAIT = 9'b010000000,
    ST_DONE   = 9'b100000000
  } state_e;

  localparam int unsigned PW = tce_pkg::POS_W;
  localparam int unsigned AW = tce_pkg::ADDR_W;
  localparam logic [PW-1:0] CELLS = PW'(tce_pkg::CELL_COUNT);
  localparam logic [PW-1:0] COLS  = PW'(tce_pkg::COLUMNS);

  state_e state_q, state_d;
  logic [PW-1:0] sweep_q, sweep_d;
  logic          copy_pend_q, copy_pend_d;
  logic [PW-1:0] cursor_q, cursor_d;
  logic [PW-1:0] base_q, base_d;
  logic [tce_pkg::CHAR_W-1:0] char_q, char_d;
  logic [tce_pkg::CHAR_W-1:0] hex_lo_q, hex_lo_d;
  logic          hex_pend_q, hex_pend_d;
  logic          scroll_nl_q, scroll_nl_d;
  logic [tce_pkg::CHAR_W-1:0] res_chr_q, res_chr_d;
  logic [tce_pkg::ATTR_W-1:0] res_att_q, res_att_d;
  logic [tce_pkg::ATTR_W-1:0] attr_q;
  logic          out_valid_q, out_valid_d;
  logic [PW-1:0] out_cur_q, out_cur_d;
  logic [tce_pkg::CHAR_W-1:0] out_chr_q, out_chr_d;
  logic [tce_pkg::ATTR_W-1:0] out_att_q, out_att_d;

  logic                        in_ready;
  logic                        mem_we, mem_re;
  logic [AW-1:0]               mem_waddr, mem_raddr;
  logic [tce_pkg::CELL_W-1:0]  mem_wdata, mem_rdata;

  logic [PW:0]   next_row;
  logic [PW:0]   cur_inc;
  logic [PW-1:0] cur_dec;
  logic [PW-1:0] copy_waddr;
  tce_pkg::tce_action_e in_action;

  assign next_row   = {1'b0, base_q} + (PW+1)'(tce_pkg::COLUMNS);
  assign cur_inc    = {1'b0, cursor_q} + (PW+1)'(1);
  assign cur_dec    = cursor_q - PW'(1);
  assign copy_waddr = sweep_q - COLS - PW'(1);
  assign in_action  = tce_pkg::tce_action_e'(in_chan.action);

  tce_ram #(
    .WIDTH(tce_pkg::CELL_W),
    .DEPTH(tce_pkg::CELL_COUNT)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    logic put_next;
    state_d     = state_q;
    sweep_d     = sweep_q;
    copy_pend_d = copy_pend_q;
    cursor_d    = cursor_q;
    base_d      = base_q;
    char_d      = char_q;
    hex_lo_d    = hex_lo_q;
    hex_pend_d  = hex_pend_q;
    scroll_nl_d = scroll_nl_q;
    res_chr_d   = res_chr_q;
    res_att_d   = res_att_q;
    out_valid_d = out_valid_q;
    out_cur_d   = out_cur_q;
    out_chr_d   = out_chr_q;
    out_att_d   = out_att_q;
    in_ready    = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    put_next    = 1'b0;

    if (out_chan.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q[AW-1:0];
        mem_wdata = {tce_pkg::BLANK_CHAR, tce_pkg::RESET_ATTR};
        if (sweep_q == CELLS - PW'(1)) begin
          sweep_d = '0;
          state_d = ST_IDLE;
        end else begin
          sweep_d = sweep_q + PW'(1);
        end
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_chan.valid) begin
          res_chr_d = '0;
          res_att_d = '0;
          state_d   = ST_DONE;
          unique case (in_action)
            tce_pkg::ACT_PUT: begin
              char_d     = in_chan.char_code;
              hex_pend_d = 1'b0;
              state_d    = ST_PUT;
            end
            tce_pkg::ACT_HEX: begin
              char_d     = tce_pkg::hex_digit(in_chan.char_code[7:4]);
              hex_lo_d   = tce_pkg::hex_digit(in_chan.char_code[3:0]);
              hex_pend_d = 1'b1;
              state_d    = ST_PUT;
            end
            tce_pkg::ACT_NEWLINE: begin
              if (next_row >= {1'b0, CELLS}) begin
                // cursor lands on the current row start once the screen moves up
                cursor_d    = base_q;
                scroll_nl_d = 1'b1;
                sweep_d     = COLS;
                copy_pend_d = 1'b0;
                state_d     = ST_COPY;
              end else begin
                cursor_d = next_row[PW-1:0];
                base_d   = next_row[PW-1:0];
              end
            end
            tce_pkg::ACT_BACKSPACE: begin
              if (cursor_q != '0) begin
                cursor_d  = cur_dec;
                if (cursor_q == base_q) begin
                  base_d = base_q - COLS;
                end
                mem_we    = 1'b1;
                mem_waddr = cur_dec[AW-1:0];
                mem_wdata = {tce_pkg::BLANK_CHAR, attr_q};
              end
            end
            tce_pkg::ACT_CLEAR: begin
              sweep_d = '0;
              state_d = ST_CLEAR;
            end
            tce_pkg::ACT_SET: begin
              cursor_d = (in_chan.position > CELLS) ? CELLS : in_chan.position;
              base_d   = '0;
              state_d  = ST_SETROW;
            end
            tce_pkg::ACT_READ: begin
              if (in_chan.position < CELLS) begin
                mem_re    = 1'b1;
                mem_raddr = in_chan.position[AW-1:0];
                state_d   = ST_RDWAIT;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_PUT: begin
        if (char_q == '0) begin
          put_next = 1'b1;
        end else if (cursor_q >= CELLS) begin
          scroll_nl_d = 1'b0;
          sweep_d     = COLS;
          copy_pend_d = 1'b0;
          state_d     = ST_COPY;
        end else if (char_q == tce_pkg::NEWLINE_CHAR) begin
          cursor_d = next_row[PW-1:0];
          base_d   = next_row[PW-1:0];
          put_next = 1'b1;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = cursor_q[AW-1:0];
          mem_wdata = {char_q, attr_q};
          cursor_d  = cur_inc[PW-1:0];
          if (cur_inc == next_row) begin
            base_d = next_row[PW-1:0];
          end
          put_next = 1'b1;
        end
        if (put_next) begin
          if (hex_pend_q) begin
            char_d     = hex_lo_q;
            hex_pend_d = 1'b0;
          end else begin
            state_d = ST_DONE;
          end
        end
      end

      ST_COPY: begin
        // each cell read is written a row above it once its read data is back
        if (sweep_q < CELLS) begin
          mem_re      = 1'b1;
          mem_raddr   = sweep_q[AW-1:0];
          sweep_d     = sweep_q + PW'(1);
          copy_pend_d = 1'b1;
        end else begin
          copy_pend_d = 1'b0;
          sweep_d     = CELLS - COLS;
          state_d     = ST_BLANK;
        end
        if (copy_pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = copy_waddr[AW-1:0];
          mem_wdata = mem_rdata;
        end
      end

      ST_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q[AW-1:0];
        mem_wdata = {tce_pkg::BLANK_CHAR, attr_q};
        if (sweep_q == CELLS - PW'(1)) begin
          if (scroll_nl_q) begin
            state_d = ST_DONE;
          end else begin
            cursor_d = cursor_q - COLS;
            base_d   = base_q - COLS;
            state_d  = ST_PUT;
          end
        end else begin
          sweep_d = sweep_q + PW'(1);
        end
      end

      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q[AW-1:0];
        mem_wdata = {tce_pkg::BLANK_CHAR, attr_q};
        if (sweep_q == CELLS - PW'(1)) begin
          cursor_d = '0;
          base_d   = '0;
          state_d  = ST_DONE;
        end else begin
          sweep_d = sweep_q + PW'(1);
        end
      end

      ST_SETROW: begin
        if (next_row <= {1'b0, cursor_q}) begin
          base_d = next_row[PW-1:0];
        end else begin
          state_d = ST_DONE;
        end
      end

      ST_RDWAIT: begin
        res_chr_d = mem_rdata[tce_pkg::CELL_W-1:tce_pkg::ATTR_W];
        res_att_d = mem_rdata[tce_pkg::ATTR_W-1:0];
        state_d   = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_q || out_chan.ready) begin
          out_valid_d = 1'b1;
          out_cur_d   = cursor_q;
          out_chr_d   = res_chr_q;
          out_att_d   = res_att_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      sweep_q     <= '0;
      copy_pend_q <= 1'b0;
      cursor_q    <= '0;
      base_q      <= '0;
      hex_pend_q  <= 1'b0;
      scroll_nl_q <= 1'b0;
      attr_q      <= tce_pkg::RESET_ATTR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      copy_pend_q <= copy_pend_d;
      cursor_q    <= cursor_d;
      base_q      <= base_d;
      hex_pend_q  <= hex_pend_d;
      scroll_nl_q <= scroll_nl_d;
      out_valid_q <= out_valid_d;
      if (cfg_chan.valid) begin
        attr_q <= cfg_chan.text_attribute;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    char_q    <= char_d;
    hex_lo_q  <= hex_lo_d;
    res_chr_q <= res_chr_d;
    res_att_q <= res_att_d;
    out_cur_q <= out_cur_d;
    out_chr_q <= out_chr_d;
    out_att_q <= out_att_d;
  end

  assign cfg_chan.ready       = 1'b1;
  assign in_chan.ready        = in_ready;
  assign out_chan.valid       = out_valid_q;
  assign out_chan.cursor_cell = out_cur_q;
  assign out_chan.cell_char   = out_chr_q;
  assign out_chan.cell_attr   = out_att_q;

endmodule
